// ===== hdl/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants for the stereo tremolo / auto-panner
// State codes, register map, fixed-point constants and the sine entry builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sta_pkg;

  typedef longint unsigned u64_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_RECIP,
    ST_GAIN,
    ST_PAN,
    ST_OUT
  } state_t;

  // per-step enables from the sequencer to the datapath
  typedef struct packed {
    logic load;      // input transfer taken
    logic mix_en;    // form the gain and pan numerators
    logic recip_en;  // divide the numerators by 100
    logic gain_en;   // sample times tremolo gain
    logic pan_en;    // mixed sample times pan gain
  } ctrl_t;

  // register map (word index, byte address = 4 * index)
  localparam int          ADDR_W        = 5;
  localparam logic [2:0]  REG_TREM_STEP = 3'd0;
  localparam logic [2:0]  REG_TREM_MIX  = 3'd1;
  localparam logic [2:0]  REG_PAN_STEP  = 3'd2;
  localparam logic [2:0]  REG_PAN_WIDTH = 3'd3;
  localparam logic [2:0]  REG_BYPASS    = 3'd4;

  localparam logic [23:0] TREM_STEP_RST = 24'd1398;
  localparam logic [6:0]  TREM_MIX_RST  = 7'd50;
  localparam logic [23:0] PAN_STEP_RST  = 24'd699;
  localparam logic [6:0]  PAN_WIDTH_RST = 7'd100;

  // LFO is Q1.16, 0..65536
  localparam logic [16:0] LFO_MID = 17'd32768;
  localparam logic [16:0] LFO_ONE = 17'd65536;
  localparam logic [6:0]  PCT_MAX = 7'd100;

  // 100*65536 + 50 and 100*32768 + 50 (rounding bias folded in)
  localparam logic [23:0]        GAIN_BIAS = 24'd6553650;
  localparam logic signed [24:0] PAN_BIAS  = 25'sd3276850;

  // floor(n/100) = (n * ceil(2^30/100)) >> 30, exact for n < 2^23
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  // Taylor sine constants, Q2.30
  localparam u64_t Q30_ONE     = 64'd1 << 30;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  // quarter-wave sine of angle x (Q2.30 radians), scaled to 0..32768
  function automatic logic [15:0] quarter_sine(input u64_t x);
    u64_t x2;
    u64_t t;
    u64_t s;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return s[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/stereo_tremolo_autopan.sv =====
// ----------------------------------------------------------------------------
// stereo_tremolo_autopan: sine tremolo followed by a sine auto-panner
// Input stream s_*: one stereo Q1.23 pair per transfer. Output stream m_*:
// one processed pair per input transfer, in order. Registers are to be written
// over the APB port while the block is idle; the block does not enforce this.
// Path: a non-bypass item goes through the mix, reciprocal, gain and pan steps
// before the output step loads it into the output register; in bypass it goes
// straight to the output step. The next input transfer is taken the cycle after
// the result is loaded, so no new item is taken before the last one is through
// the six-step sequencer that walks it through the gain unit and both lanes.
// A finished result waits in the output register while s_tready is high
// again, so the input side keeps moving; if the receiver still stalls when
// the next result is ready, the sequencer holds in its output step.
// Reset (rst, synchronous): phases clear to 0, registers take their defaults
// (step 1398, mix 50, step 699, width 100, bypass off), no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_tremolo_autopan #(
  parameter  int PHASE_BITS       = 24,
  parameter  int SINE_TABLE_DEPTH = 1024,
  parameter  int SAMPLE_BITS      = 24,
  localparam int DataW            = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input stream
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [DataW-1:0]           s_tdata,  // left_in, right_in
  // output stream
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [DataW-1:0]           m_tdata,  // left_out, right_out
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sta_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  // configuration registers
  logic [23:0] trem_step;
  logic [6:0]  trem_mix;
  logic [23:0] pan_step;
  logic [6:0]  pan_width;
  logic        bypass;

  sta_pkg::state_t state;
  sta_pkg::state_t state_next;
  sta_pkg::ctrl_t  ctrl;

  logic                   accept;
  logic                   advance;
  logic                   out_load;
  logic                   byp_item;   // bypass as seen by the current item
  logic                   cfg_wr;
  logic [2:0]             reg_idx;
  logic [16:0]            lfo_trem;
  logic [16:0]            lfo_pan;
  logic [16:0]            gain;
  logic [16:0]            pan_l;
  logic [16:0]            pan_r;
  logic [SAMPLE_BITS-1:0] left_res;
  logic [SAMPLE_BITS-1:0] right_res;
  logic [SAMPLE_BITS-1:0] left_q;
  logic [SAMPLE_BITS-1:0] right_q;

  //--------------------------------------------------------------------------
  // APB register file; pready is tied high, writes land on the access cycle
  //--------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trem_step <= sta_pkg::TREM_STEP_RST;
      trem_mix  <= sta_pkg::TREM_MIX_RST;
      pan_step  <= sta_pkg::PAN_STEP_RST;
      pan_width <= sta_pkg::PAN_WIDTH_RST;
      bypass    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sta_pkg::REG_TREM_STEP: trem_step <= pwdata[23:0];
        sta_pkg::REG_TREM_MIX:  trem_mix  <= pwdata[6:0];
        sta_pkg::REG_PAN_STEP:  pan_step  <= pwdata[23:0];
        sta_pkg::REG_PAN_WIDTH: pan_width <= pwdata[6:0];
        sta_pkg::REG_BYPASS:    bypass    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sta_pkg::REG_TREM_STEP: prdata = 32'(trem_step);
      sta_pkg::REG_TREM_MIX:  prdata = 32'(trem_mix);
      sta_pkg::REG_PAN_STEP:  prdata = 32'(pan_step);
      sta_pkg::REG_PAN_WIDTH: prdata = 32'(pan_width);
      sta_pkg::REG_BYPASS:    prdata = 32'(bypass);
      default:                prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sequencer: one item at a time through LFO, gain unit and the lanes
  //--------------------------------------------------------------------------
  assign s_tready = (state == sta_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  // phases hold while bypassed
  assign advance  = accept && !bypass;
  // output register is free or being drained this cycle
  assign out_load = (state == sta_pkg::ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sta_pkg::ST_IDLE;
      byp_item <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        byp_item <= bypass;
      end
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.load     = accept;
    ctrl.mix_en   = 1'b0;
    ctrl.recip_en = 1'b0;
    ctrl.gain_en  = 1'b0;
    ctrl.pan_en   = 1'b0;
    unique case (state)
      sta_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = bypass ? sta_pkg::ST_OUT : sta_pkg::ST_MIX;
        end
      end
      sta_pkg::ST_MIX: begin
        ctrl.mix_en = 1'b1;
        state_next  = sta_pkg::ST_RECIP;
      end
      sta_pkg::ST_RECIP: begin
        ctrl.recip_en = 1'b1;
        state_next    = sta_pkg::ST_GAIN;
      end
      sta_pkg::ST_GAIN: begin
        ctrl.gain_en = 1'b1;
        state_next   = sta_pkg::ST_PAN;
      end
      sta_pkg::ST_PAN: begin
        ctrl.pan_en = 1'b1;
        state_next  = sta_pkg::ST_OUT;
      end
      sta_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = sta_pkg::ST_IDLE;
        end
      end
      default: state_next = sta_pkg::ST_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Datapath: two LFOs, shared gain unit, one lane per channel
  //--------------------------------------------------------------------------
  sta_lfo #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lfo_trem (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .step    (trem_step),
    .lfo     (lfo_trem)
  );

  sta_lfo #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lfo_pan (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .step    (pan_step),
    .lfo     (lfo_pan)
  );

  sta_gain u_gain (
    .clk      (clk),
    .ctrl     (ctrl),
    .lfo_trem (lfo_trem),
    .lfo_pan  (lfo_pan),
    .mix      (trem_mix),
    .width    (pan_width),
    .gain     (gain),
    .pan_l    (pan_l),
    .pan_r    (pan_r)
  );

  sta_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk        (clk),
    .ctrl       (ctrl),
    .byp        (byp_item),
    .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
    .gain       (gain),
    .pan        (pan_l),
    .sample_out (left_res)
  );

  sta_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk        (clk),
    .ctrl       (ctrl),
    .byp        (byp_item),
    .sample_in  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .gain       (gain),
    .pan        (pan_r),
    .sample_out (right_res)
  );

  //--------------------------------------------------------------------------
  // Output register: joins both lanes into one transfer
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_q  <= left_res;
      right_q <= right_res;
    end
  end

  assign m_tdata = DataW'({right_q, left_q});

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  a_full_path: assert property (@(posedge clk) disable iff (rst)
    (accept && !bypass) |-> ##5 (state == sta_pkg::ST_OUT))
    else $error("effect item did not reach the output step on time");

  a_bypass_path: assert property (@(posedge clk) disable iff (rst)
    (accept && bypass) |=> (state == sta_pkg::ST_OUT))
    else $error("bypass item did not go straight to the output step");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == sta_pkg::ST_OUT))
    else $error("result appeared without passing the output step");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == sta_pkg::ST_OUT && m_tvalid && !m_tready) |=> (state == sta_pkg::ST_OUT))
    else $error("pending result would be overwritten");

endmodule

`default_nettype wire

// ===== hdl/sta_lfo.sv =====
// ----------------------------------------------------------------------------
// sta_lfo: phase accumulator and quarter-wave sine ROM
// Registered ROM read with the phase before it advances; LFO out in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_lfo #(
  parameter int PHASE_BITS       = 24,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [23:0] step,
  output logic      [16:0] lfo
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int NW = AW - 1;
  localparam int QD = SINE_TABLE_DEPTH / 4;
  localparam int SW = (PHASE_BITS > 24) ? PHASE_BITS : 24;

  logic [PHASE_BITS-1:0] phase;
  logic [SW-1:0]         phase_sum;
  logic [AW-1:0]         idx;
  logic [NW-1:0]         low;
  logic [NW-1:0]         n4;
  logic [15:0]           rom [QD+1];
  logic [15:0]           sine;
  logic                  neg;

  // quarter wave, entry g holds the sine at n = 4*g
  for (genvar g = 0; g <= QD; g++) begin : g_rom
    localparam sta_pkg::u64_t X =
      (sta_pkg::u64_t'(4 * g) * sta_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign rom[g] = sta_pkg::quarter_sine(X);
  end

  assign phase_sum = SW'(phase) + SW'(step);
  assign idx       = phase[PHASE_BITS-1 -: AW];
  assign low       = NW'(idx[AW-3:0]);
  // odd quadrants run the table backwards
  assign n4        = idx[AW-2] ? (NW'(QD) - low) : low;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase_sum[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sine <= rom[n4];
      neg  <= idx[AW-1];
    end
  end

  assign lfo = neg ? (sta_pkg::LFO_MID - 17'(sine)) : (sta_pkg::LFO_MID + 17'(sine));

endmodule

`default_nettype wire

// ===== hdl/sta_gain.sv =====
// ----------------------------------------------------------------------------
// sta_gain: tremolo gain and left/right pan gains from the two LFOs
// Two steps: numerators, then divide by 100 through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_gain (
  input  wire logic          clk,
  input  wire sta_pkg::ctrl_t ctrl,
  input  wire logic [16:0]   lfo_trem,
  input  wire logic [16:0]   lfo_pan,
  input  wire logic [6:0]    mix,
  input  wire logic [6:0]    width,
  output logic      [16:0]   gain,
  output logic      [16:0]   pan_l,
  output logic      [16:0]   pan_r
);

  logic [6:0]         mix_c;
  logic [6:0]         width_c;
  logic [16:0]        trem_depth;
  logic [23:0]        trem_prod;
  logic signed [17:0] pan_dev;
  logic signed [24:0] pan_prod;
  logic [22:0]        num_g;
  logic [22:0]        num_l;
  logic [22:0]        num_r;
  logic [46:0]        q_g;
  logic [46:0]        q_l;
  logic [46:0]        q_r;

  // percent values above 100 count as 100
  assign mix_c      = (mix > sta_pkg::PCT_MAX) ? sta_pkg::PCT_MAX : mix;
  assign width_c    = (width > sta_pkg::PCT_MAX) ? sta_pkg::PCT_MAX : width;
  assign trem_depth = sta_pkg::LFO_ONE - lfo_trem;
  assign trem_prod  = 24'(mix_c) * 24'(trem_depth);
  assign pan_dev    = $signed({1'b0, lfo_pan}) - $signed({1'b0, sta_pkg::LFO_MID});
  assign pan_prod   = 25'(pan_dev) * $signed({1'b0, width_c});

  // all numerators stay in 50..6553650
  always_ff @(posedge clk) begin
    if (ctrl.mix_en) begin
      num_g <= 23'(sta_pkg::GAIN_BIAS - trem_prod);
      num_l <= 23'(sta_pkg::PAN_BIAS - pan_prod);
      num_r <= 23'(sta_pkg::PAN_BIAS + pan_prod);
    end
  end

  assign q_g = 47'(num_g) * 47'(sta_pkg::RECIP_100);
  assign q_l = 47'(num_l) * 47'(sta_pkg::RECIP_100);
  assign q_r = 47'(num_r) * 47'(sta_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (ctrl.recip_en) begin
      gain  <= q_g[sta_pkg::RECIP_SHIFT +: 17];
      pan_l <= q_l[sta_pkg::RECIP_SHIFT +: 17];
      pan_r <= q_r[sta_pkg::RECIP_SHIFT +: 17];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sta_lane.sv =====
// ----------------------------------------------------------------------------
// sta_lane: one channel's gain path
// Sample times tremolo gain, round and saturate, times pan gain, again.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_lane #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire sta_pkg::ctrl_t         ctrl,
  input  wire logic                   byp,
  input  wire logic [SAMPLE_BITS-1:0] sample_in,
  input  wire logic [16:0]            gain,
  input  wire logic [16:0]            pan,
  output logic      [SAMPLE_BITS-1:0] sample_out
);

  localparam int PW = SAMPLE_BITS + 18;
  localparam int QW = PW - 16;
  localparam logic signed [PW-1:0] Round = PW'(32768);

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] mixed;
  logic signed [PW-1:0]          p_trem;
  logic signed [PW-1:0]          p_pan;

  // clamp a wide quotient to the sample range
  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [QW-1:0] q);
    logic [2:0] top;
    top = q[QW-1 -: 3];
    if (top == 3'b000 || top == 3'b111) begin
      return q[SAMPLE_BITS-1:0];
    end else if (q[QW-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= sample_in;
    end
    if (ctrl.gain_en) begin
      p_trem <= x * $signed({1'b0, gain}) + Round;
    end
    if (ctrl.pan_en) begin
      p_pan <= mixed * $signed({1'b0, pan}) + Round;
    end
  end

  // arithmetic shift gives floor division by 65536
  assign mixed      = sat(QW'(p_trem >>> 16));
  assign sample_out = byp ? x : sat(QW'(p_pan >>> 16));

endmodule

`default_nettype wire
